// ----- design/chs_pkg.sv -----
// Package for the compass heading block: payload types, constants, arctangent table.
`default_nettype none
package chs_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STEPS    = 16;

  localparam int HEADING_FRAC = 7;
  localparam int TABLE_LEN    = 24;
  localparam int TABLE_FRAC   = 16;
  localparam int GUARD_SHIFT  = 8;

  // datapath widths
  localparam int XY_W    = 28;
  localparam int Z_W     = ANGLE_FRAC_BITS + 11;
  localparam int SHIFT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int SUM_W   = 19;
  localparam int WIDE_W  = 32;

  localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(180 << ANGLE_FRAC_BITS);

  // angle to heading unit conversion
  localparam int RND_SHIFT =
    (ANGLE_FRAC_BITS >= HEADING_FRAC) ? ANGLE_FRAC_BITS - HEADING_FRAC : 0;
  localparam int UP_SHIFT =
    (ANGLE_FRAC_BITS < HEADING_FRAC) ? HEADING_FRAC - ANGLE_FRAC_BITS : 0;
  localparam logic signed [WIDE_W-1:0] RND_HALF =
    (RND_SHIFT > 0) ? WIDE_W'(1 << (RND_SHIFT - 1)) : '0;

  localparam logic signed [SUM_W-1:0] FULL_TURN = SUM_W'(46080);
  localparam logic signed [SUM_W-1:0] TWO_TURNS = SUM_W'(92160);

  // sector = floor((h + 1439) / 2880) mod 16, with 2880 = 64 * 45
  localparam logic [16:0] SECTOR_BIAS  = 17'd1439;
  localparam int          SECTOR_SHIFT = 6;
  localparam logic [10:0] SECTOR_RECIP = 11'd1457;  // ceil(2^16 / 45)

  localparam logic signed [15:0] DECL_RESET = 16'sd1461;

  // atan(2^-i) in degrees, units of 2^-16 degree
  localparam logic [22:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
    23'd234379,  23'd117304,  23'd58666,  23'd29335,
    23'd14668,   23'd7334,    23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,
    23'd57,      23'd29,      23'd14,     23'd7,
    23'd4,       23'd2,       23'd1,      23'd0
  };

  typedef struct packed {
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
  } sample_t;

  typedef struct packed {
    logic [15:0] heading;
    logic [3:0]  sector;
  } result_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
  } vec_t;

  // per-step angle increment, rounded half up to the accumulator resolution
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    logic [23:0] t;
    t = {1'b0, ATAN_DEG_Q16[i]} + (24'd1 << (TABLE_FRAC - ANGLE_FRAC_BITS - 1));
    return Z_W'(t >> (TABLE_FRAC - ANGLE_FRAC_BITS));
  endfunction

endpackage
`default_nettype wire

// ----- design/chs_prep.sv -----
// Input cell: guard scaling, half-turn pre-rotation for negative x, zero detect.
`default_nettype none
module chs_prep import chs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire sample_t up_data,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output vec_t         dn_data
);

  logic vld;
  vec_t vec;
  vec_t vec_next;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  always_comb begin
    xs = XY_W'(up_data.field_x) <<< GUARD_SHIFT;
    ys = XY_W'(up_data.field_y) <<< GUARD_SHIFT;
    vec_next.zero = (up_data.field_x == '0) && (up_data.field_y == '0);
    if (xs[XY_W-1]) begin
      vec_next.x = -xs;
      vec_next.y = -ys;
      vec_next.z = ys[XY_W-1] ? -HALF_TURN_Z : HALF_TURN_Z;
    end else begin
      vec_next.x = xs;
      vec_next.y = ys;
      vec_next.z = '0;
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      vec <= vec_next;
    end
  end

  assign dn_valid = vld;
  assign dn_data  = vec;

endmodule
`default_nettype wire

// ----- design/chs_cell.sv -----
// One vectoring CORDIC iteration with its own word register and handshake.
`default_nettype none
module chs_cell import chs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [SHIFT_W-1:0]    shift,
  input  wire logic signed [Z_W-1:0] step_angle,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire vec_t                  up_data,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output vec_t                       dn_data
);

  logic vld;
  vec_t vec;
  vec_t vec_next;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  always_comb begin
    dx = up_data.y >>> shift;
    dy = up_data.x >>> shift;
    vec_next.zero = up_data.zero;
    // y >= 0: rotate clockwise
    if (!up_data.y[XY_W-1]) begin
      vec_next.x = up_data.x + dx;
      vec_next.y = up_data.y - dy;
      vec_next.z = up_data.z + step_angle;
    end else begin
      vec_next.x = up_data.x - dx;
      vec_next.y = up_data.y + dy;
      vec_next.z = up_data.z - step_angle;
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      vec <= vec_next;
    end
  end

  assign dn_valid = vld;
  assign dn_data  = vec;

endmodule
`default_nettype wire

// ----- design/chs_post.sv -----
// Output stages: rounding plus declination, wrap into one turn, sector lookup.
`default_nettype none
module chs_post import chs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [15:0] declination,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire vec_t               up_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output result_t                 out_word
);

  logic vld_a;
  logic vld_b;
  logic vld_c;
  logic rdy_a;
  logic rdy_b;
  logic rdy_c;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [WIDE_W-1:0] ang;
  logic signed [WIDE_W-1:0] ang_units;

  logic [15:0]             head_b;
  logic [15:0]             head_b_next;
  logic signed [SUM_W-1:0] wrapped;

  result_t             res;
  logic [16:0]         biased;
  logic [9:0]          coarse;
  logic [20:0]         prod;
  result_t             res_next;

  assign rdy_c    = !vld_c || out_ready;
  assign rdy_b    = !vld_b || rdy_c;
  assign rdy_a    = !vld_a || rdy_b;
  assign up_ready = rdy_a;

  // stage A: angle to 1/128 degree, round half up, add declination
  always_comb begin
    ang       = up_data.zero ? '0 : WIDE_W'(up_data.z);
    ang_units = ((ang + RND_HALF) >>> RND_SHIFT) <<< UP_SHIFT;
    sum_next  = SUM_W'(ang_units) + SUM_W'(declination);
  end

  // stage B: sum lies within two turns either side of zero
  always_comb begin
    if (sum < -FULL_TURN) begin
      wrapped = sum + TWO_TURNS;
    end else if (sum < 0) begin
      wrapped = sum + FULL_TURN;
    end else if (sum >= FULL_TURN) begin
      wrapped = sum - FULL_TURN;
    end else begin
      wrapped = sum;
    end
    head_b_next = wrapped[15:0];
  end

  // stage C: divide by 2880 as a shift by 6 and a reciprocal multiply for 45
  always_comb begin
    biased           = {1'b0, head_b} + SECTOR_BIAS;
    coarse           = biased[SECTOR_SHIFT +: 10];
    prod             = 21'(coarse) * 21'(SECTOR_RECIP);
    res_next.heading = head_b;
    res_next.sector  = prod[19:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a <= up_valid;
      end
      if (rdy_b) begin
        vld_b <= vld_a;
      end
      if (rdy_c) begin
        vld_c <= vld_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy_a) begin
      sum <= sum_next;
    end
    if (vld_a && rdy_b) begin
      head_b <= head_b_next;
    end
    if (vld_b && rdy_c) begin
      res <= res_next;
    end
  end

  assign out_valid = vld_c;
  assign out_word  = res;

  a_heading_in_turn: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.heading < 16'd46080))
    else $error("heading outside one turn");

  a_north_sector: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((out_word.heading <= 16'd1440) || (out_word.heading > 16'd44640))
                   == (out_word.sector == 4'd0)))
    else $error("north sector mismatch");

  a_wrap_passthru: assert property (@(posedge clk) disable iff (rst)
    (vld_a && rdy_b && (sum >= 0) && (sum < FULL_TURN)) |=> (head_b == $past(sum[15:0])))
    else $error("in-range sum altered by wrap");

endmodule
`default_nettype wire

// ----- design/compass_heading_sector_top.sv -----
// Pipeline: 1 input cell, then CORDIC_STEPS iteration cells, then 3 output stages.
// Throughput: one word per cycle while out_ready is high; every stage holds one word and has its own ready.
// The CORDIC cells form a chain, one iteration per cell.
// Backpressure stalls only the stages that are full.
// Reset (synchronous, rst high) empties all stages and sets declination to 1461.
`default_nettype none
module compass_heading_sector_top import chs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sample_t            in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output result_t                 out_word,
  input  wire logic               wr_en,
  input  wire logic signed [15:0] wr_data
);

  logic signed [15:0] declination;

  logic vld [CORDIC_STEPS+1];
  logic rdy [CORDIC_STEPS+1];
  vec_t vec [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      declination <= DECL_RESET;
    end else if (wr_en) begin
      declination <= wr_data;
    end
  end

  chs_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_word),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn_data  (vec[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    chs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (SHIFT_W'(i)),
      .step_angle (atan_step(i)),
      .up_valid   (vld[i]),
      .up_ready   (rdy[i]),
      .up_data    (vec[i]),
      .dn_valid   (vld[i+1]),
      .dn_ready   (rdy[i+1]),
      .dn_data    (vec[i+1])
    );
  end

  chs_post u_post (
    .clk         (clk),
    .rst         (rst),
    .declination (declination),
    .up_valid    (vld[CORDIC_STEPS]),
    .up_ready    (rdy[CORDIC_STEPS]),
    .up_data     (vec[CORDIC_STEPS]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule
`default_nettype wire

// ----- sim/chs_checker.sv -----
// Checker for the compass heading block: tracks declination, predicts each result, compares.
`timescale 1ns / 1ps
module chs_checker import chs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sample_t            in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  result_t            out_word,
  input  logic               wr_en,
  input  logic signed [15:0] wr_data,
  output int                 errors,
  output int                 pending,
  output int                 checked,
  output logic [15:0]        sectors_seen
);

  localparam int             HEAD_FRAC    = 7;
  localparam longint         TURN_UNITS   = 46080;
  localparam logic signed [15:0] DECL_AT_RESET = 16'sd1461;
  localparam int             MAX_PRINTED  = 40;

  // atan(2^-i) in degrees, 2^-16 degree units
  localparam longint ARCTAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    sample_t smp;
    result_t res;
  } heading_exp_t;

  heading_exp_t       heading_q [$];
  logic signed [15:0] decl_setting;

  function automatic result_t predict_heading(input logic signed [15:0] fx,
                                              input logic signed [15:0] fy,
                                              input logic signed [15:0] decl);
    longint  x, y, z, dx, dy, step, a, h;
    int      i, s;
    result_t r;
    x = fx;
    y = fy;
    z = 0;
    if (x != 0 || y != 0) begin
      x = x * 256;
      y = y * 256;
      // left half plane: pre-rotate by a half turn
      if (x < 0) begin
        z = (y >= 0) ? (longint'(180) <<< ANGLE_FRAC_BITS)
                     : -(longint'(180) <<< ANGLE_FRAC_BITS);
        x = -x;
        y = -y;
      end
      for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        step = (ARCTAN_Q16[i] + (longint'(1) <<< (15 - ANGLE_FRAC_BITS)))
               >>> (16 - ANGLE_FRAC_BITS);
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + step;
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - step;
        end
      end
    end
    s = ANGLE_FRAC_BITS - HEAD_FRAC;
    if (s > 0) begin
      a = (z + (longint'(1) <<< (s - 1))) >>> s;
    end else if (s == 0) begin
      a = z;
    end else begin
      a = z <<< (-s);
    end
    h = (a + longint'(decl)) % TURN_UNITS;
    if (h < 0) begin
      h = h + TURN_UNITS;
    end
    r.heading = 16'(h);
    if (h > 44640 || h <= 1440) begin
      r.sector = 4'd0;
    end else begin
      r.sector = 4'((h - 1441) / 2880 + 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    heading_exp_t exp_word;
    if (rst) begin
      decl_setting = DECL_AT_RESET;
      heading_q.delete();
      errors       = 0;
      checked      = 0;
      sectors_seen = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (heading_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word heading=%0d sector=%0d",
                                    out_word.heading, out_word.sector));
        end else begin
          exp_word = heading_q.pop_front();
          checked++;
          sectors_seen[exp_word.res.sector] = 1'b1;
          if (out_word.heading !== exp_word.res.heading) begin
            report_mismatch($sformatf("x=%0d y=%0d heading got %0d want %0d",
                                      exp_word.smp.field_x, exp_word.smp.field_y,
                                      out_word.heading, exp_word.res.heading));
          end
          if (out_word.sector !== exp_word.res.sector) begin
            report_mismatch($sformatf("x=%0d y=%0d sector got %0d want %0d",
                                      exp_word.smp.field_x, exp_word.smp.field_y,
                                      out_word.sector, exp_word.res.sector));
          end
        end
      end
      if (in_valid && in_ready) begin
        exp_word.smp = in_word;
        exp_word.res = predict_heading(in_word.field_x, in_word.field_y, decl_setting);
        heading_q.push_back(exp_word);
      end
      if (wr_en) begin
        decl_setting = wr_data;
      end
    end
    pending = heading_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the compass heading block: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top import chs_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 210;
  localparam int DRAIN_CYCLES   = 30;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  sample_t            in_word   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  result_t            out_word;
  logic               wr_en     = 1'b0;
  logic signed [15:0] wr_data   = '0;

  int          chk_errors, chk_pending, chk_checked;
  logic [15:0] chk_sectors;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int n_sent     = 0;
  int n_settings = 0;
  int quiet_cycles = 0;

  compass_heading_sector_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .wr_en     (wr_en),
    .wr_data   (wr_data)
  );

  chs_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .wr_en        (wr_en),
    .wr_data      (wr_data),
    .errors       (chk_errors),
    .pending      (chk_pending),
    .checked      (chk_checked),
    .sectors_seen (chk_sectors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d still owed",
               quiet_cycles, chk_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [15:0] fx, input logic signed [15:0] fy);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= sample_t'({fx, fy});
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // hold the sender until every owed result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    @(posedge clk);
  endtask

  task automatic set_declination(input logic signed [15:0] value);
    drain_results();
    wr_en   <= 1'b1;
    wr_data <= value;
    @(posedge clk);
    wr_en   <= 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [15:0] extreme_val();
    case ($urandom_range(4))
      0:       return -16'sd32768;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    logic signed [15:0] a, b;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        a = 16'($urandom);
        b = 16'($urandom);
      end
      6: begin
        a = 16'($urandom_range(8)) - 16'sd4;
        b = 16'($urandom_range(8)) - 16'sd4;
      end
      7: begin
        a = 16'($urandom);
        b = 16'sd0;
        if ($urandom_range(1)) begin
          b = a;
          a = 16'sd0;
        end
      end
      8: begin
        a = extreme_val();
        b = extreme_val();
      end
      default: begin
        a = 16'($urandom);
        b = $urandom_range(1) ? a : -a;
      end
    endcase
    return sample_t'({a, b});
  endfunction

  initial begin
    sample_t            smp;
    logic signed [15:0] decl;
    int                 p, k;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // axes, corners, zero vector and the half-turn split on the negative x axis
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd0);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, 16'sd32767);
    send_sample(16'sd0, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd1, 16'sd0);
    send_sample(-16'sd1, -16'sd1);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd1, -16'sd1);
    send_sample(16'sd1, 16'sd1);

    // zero vector puts the heading right on the north sector edges
    set_declination(16'sd1440);
    send_sample(16'sd0, 16'sd0);
    set_declination(16'sd1441);
    send_sample(16'sd0, 16'sd0);
    set_declination(-16'sd1440);
    send_sample(16'sd0, 16'sd0);
    set_declination(-16'sd1439);
    send_sample(16'sd0, 16'sd0);
    set_declination(-16'sd1);
    send_sample(16'sd0, 16'sd0);
    // half turn plus a half-turn declination lands next to the wrap at one full turn
    set_declination(16'sd23040);
    send_sample(-16'sd1, 16'sd0);

    for (p = 0; p < 8; p++) begin
      case (p)
        0:       decl = 16'sd1461;
        1:       decl = -16'sd23040;
        2:       decl = 16'sd23040;
        3:       decl = 16'sd0;
        4:       decl = 16'sh7fff;
        5:       decl = 16'sh8000;
        default: decl = 16'(int'($urandom_range(46080)) - 23040);
      endcase
      set_declination(decl);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (k == PHASE_WORDS / 2) begin
          drain_results();
        end
        smp = rand_sample();
        send_sample(smp.field_x, smp.field_y);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples under %0d declination settings and four pacing modes",
             n_sent, n_settings);
    $display("Checked %0d results, %0d of 16 compass sectors reached",
             chk_checked, $countones(chk_sectors));
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
